[src/arfp_pkg.sv]
// Shared types and field constants for the ARM relocation field patcher.
package arfp_pkg;

    typedef enum logic [2:0] {
        OP_DATA   = 3'd0,
        OP_PCREL  = 3'd1,
        OP_VFP    = 3'd2,
        OP_BRANCH = 3'd3,
        OP_ROTIMM = 3'd4,
        OP_SHIFT  = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_RANGE   = 2'd1,
        ST_NOENC   = 2'd2,
        ST_UNKNOWN = 2'd3
    } status_t;

    localparam logic [31:0] FLD_BRANCH = 32'h00ff_ffff;
    localparam logic [31:0] FLD_ROTIMM = 32'h0000_0fff;
    localparam logic [31:0] FLD_SHIFT  = 32'h0000_0f80;
    localparam logic [31:0] UP_BIT     = 32'h0080_0000;
    localparam logic [31:0] MAX_IMM12  = 32'h0000_0fff;
    localparam logic [31:0] MAX_IMM8   = 32'h0000_00ff;
    localparam int          SHIFT_LSB  = 7;
    localparam logic signed [32:0] SHIFT_FULL = 33'sd32;

endpackage

[src/arm_reloc_field_patcher.sv]
// ARM relocation field patcher: one relocation in, one patched word and status out.
//
// Input channel: in_valid/in_ready carry op, value, byte_count and word_in.
// Output channel: out_valid/out_ready carry word_out and status.
// A transfer happens on a rising edge with valid and ready both high.
//
// The block is a two-register pipeline: an input register, then the patch
// logic, then the result register. out_valid rises once the item has moved
// from the input register into the result register. Throughput is one item
// per cycle while the receiver does not stall, set by the single pass through
// the patch logic (sixteen rotation candidates are checked side by side).
//
// Reset (rst_n low, asynchronous) empties both registers; in_ready is high
// right after reset. When the receiver stalls, the result register holds
// its data and the input register still takes one more item before
// in_ready drops.
module arm_reloc_field_patcher
    import arfp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         op,
    input  logic signed [32:0] value,
    input  logic [2:0]         byte_count,
    input  logic [31:0]        word_in,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [31:0]        word_out,
    output logic [1:0]         status
);

    logic               s1_valid_reg;
    logic [2:0]         op_reg;
    logic signed [32:0] value_reg;
    logic [2:0]         count_reg;
    logic [31:0]        word_reg;
    logic               out_valid_reg;
    logic [31:0]        word_out_reg;
    logic [1:0]         status_reg;

    logic               out_free;
    logic               s1_adv;
    logic [31:0]        word_next;
    logic [1:0]         status_next;

    assign out_free = !out_valid_reg || out_ready;
    assign s1_adv   = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (out_free)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg    <= op;
            value_reg <= value;
            count_reg <= byte_count;
            word_reg  <= word_in;
        end
        if (s1_adv)
        begin
            word_out_reg <= word_next;
            status_reg   <= status_next;
        end
    end

    // Patch logic
    logic signed [33:0] d;
    logic [33:0]        absd;
    logic [31:0]        low;
    logic [31:0]        rot [16];
    logic [15:0]        fits;
    logic [11:0]        rot_field;
    logic               rot_found;
    logic               vfp_up;
    logic [4:0]         amt;

    assign low  = value_reg[31:0];
    assign d    = 34'(value_reg) - 34'sd4;
    assign absd = d[33] ? 34'(-d) : 34'(d);
    // trunc-toward-zero quotient is non-negative for d in -3..-1
    assign vfp_up = !d[33] || (absd < 34'd4);
    assign amt  = (value_reg == SHIFT_FULL) ? 5'd0 : low[4:0];

    always_comb
    begin
        for (int k = 0; k < 16; k++)
        begin
            rot[k]  = (low << (2 * k)) | (low >> ((32 - 2 * k) % 32));
            fits[k] = (rot[k][31:8] == 24'd0);
        end
    end

    always_comb
    begin
        rot_field = 12'd0;
        rot_found = 1'b0;
        for (int k = 15; k >= 0; k--)
        begin
            if (fits[k])
            begin
                rot_field = {4'(k), rot[k][7:0]};
                rot_found = 1'b1;
            end
        end
    end

    always_comb
    begin
        word_next   = word_reg;
        status_next = ST_OK;
        unique case (op_reg)
            OP_DATA:
            begin
                if (count_reg == 3'd4)
                    word_next = low;
                else if (count_reg == 3'd2)
                    word_next = {word_reg[31:16], low[15:0]};
                else if (count_reg == 3'd1)
                    word_next = {word_reg[31:8], low[7:0]};
            end
            OP_PCREL:
            begin
                if (absd > 34'(MAX_IMM12))
                    status_next = ST_RANGE;
                else
                    word_next = (word_reg & ~(UP_BIT | MAX_IMM12))
                              | (d[33] ? 32'd0 : UP_BIT) | 32'(absd[11:0]);
            end
            OP_VFP:
            begin
                if (absd[33:2] > MAX_IMM8)
                    status_next = ST_RANGE;
                else
                    word_next = (word_reg & ~(UP_BIT | MAX_IMM8))
                              | (vfp_up ? UP_BIT : 32'd0) | 32'(absd[9:2]);
            end
            OP_BRANCH:
                word_next = (word_reg & ~FLD_BRANCH) | {8'd0, d[25:2]};
            OP_ROTIMM:
            begin
                if (!rot_found)
                    status_next = ST_NOENC;
                word_next = (word_reg & ~FLD_ROTIMM) | 32'(rot_field);
            end
            OP_SHIFT:
                word_next = (word_reg & ~FLD_SHIFT) | (32'(amt) << SHIFT_LSB);
            default:
                status_next = ST_UNKNOWN;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign word_out  = word_out_reg;
    assign status    = status_reg;

endmodule

[src/arfp_checker.sv]
// Port-level checks for the ARM relocation field patcher, bound to the top level.
module arfp_checker
    import arfp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [2:0]  op,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] word_out,
    input logic [1:0]  status
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(word_out) && $stable(status))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result valid during reset");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) ##1 out_ready |=> out_valid)
        else $error("accepted item did not reach the output");

    a_unknown: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && op > 3'(OP_SHIFT)) ##1 out_ready
        |=> status == 2'(ST_UNKNOWN))
        else $error("unknown kind not flagged");

    a_branch_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && op == 3'(OP_BRANCH)) ##1 out_ready
        |=> status == 2'(ST_OK))
        else $error("branch kind flagged");

endmodule

bind arm_reloc_field_patcher arfp_checker u_arfp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .word_out  (word_out),
    .status    (status)
);
